>>> sv/assert_macros.svh
// Assertion helpers, included by the tracker unit to check its own logic.
// Each macro expects a clock named clk and an active low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

>>> sv/hklt_pkg.sv
`timescale 1ns / 1ps

package hklt_pkg;

	localparam int TAG_W   = 64;
	localparam int COUNT_W = 32;
	localparam int TIME_W  = 32;
	localparam int RANK_W  = 6;
	localparam int LIMIT_W = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd10;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  created;
	} entry_t;

	typedef struct packed {
		logic             capture;
		logic             is_read;
		logic [TAG_W-1:0] key;
	} cell_ctrl_t;

endpackage

>>> sv/hot_key_lru_tracker_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Recency table of key tags held in a row of cells, rank 0 (most recent) first.
// Commands: raise start with command, key_tag, access_time and read_rank; the command
// is taken at a rising edge where start is high and busy is low.
// A record moves the matching entry to the front, or inserts the new tag at the front,
// replacing the least recently used entry once the occupancy reaches tracked_limit.
// A read returns the entry at read_rank, its access count and its age.
// Result: an accepted command is registered in valid_s1 and then in done_q; done is high
// for one cycle, with was_hit, evicted, entry_valid, entry_tag, entry_count, entry_age.
// A new command is not taken while busy is high; busy stays high for the one cycle in which
// the captured match vector drives the single shift of the cell row.
// The result is shown for exactly one cycle and the receiver cannot stall it.
// Configuration: cfg_data (tracked_limit) is written on cfg_valid, cfg_ready is always
// high; write it only while no command is in flight.
// Reset: the occupancy is cleared and tracked_limit returns to 10; entry contents are
// left as they are and are never shown before they are written.
module hot_key_lru_tracker_unit import hklt_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [TAG_W-1:0]   key_tag,
	input  logic [TIME_W-1:0]  access_time,
	input  logic [RANK_W-1:0]  read_rank,
	output logic               done,
	output logic               was_hit,
	output logic               evicted,
	output logic               entry_valid,
	output logic [TAG_W-1:0]   entry_tag,
	output logic [COUNT_W-1:0] entry_count,
	output logic [TIME_W-1:0]  entry_age,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam int LIM_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
	localparam int RK_W  = (OCC_W > RANK_W) ? OCC_W : RANK_W;

	logic [LIMIT_W-1:0] limit_q;
	logic [OCC_W-1:0]   occ_q;
	logic               valid_s1;
	logic               cmd_s1;
	logic [TAG_W-1:0]   key_s1;
	logic [TIME_W-1:0]  time_s1;

	logic               done_q;
	logic               was_hit_q;
	logic               evicted_q;
	logic               entry_valid_q;
	logic [TAG_W-1:0]   tag_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  age_q;

	logic       accept;
	logic       upd;
	logic       hit;
	logic       room;
	logic [LIM_W-1:0] lim_eff;
	logic [OCC_W-1:0] bound;
	cell_ctrl_t ctrl;
	entry_t     front;

	entry_t held  [MAX_ENTRIES];
	entry_t acc_c [MAX_ENTRIES+1];
	logic   seen_c[MAX_ENTRIES+1];

	assign accept    = start & ~busy;
	assign busy      = valid_s1;
	assign cfg_ready = 1'b1;

	assign ctrl.capture = accept;
	assign ctrl.is_read = (command == CMD_READ);
	assign ctrl.key     = key_tag;

	assign upd = valid_s1 & (cmd_s1 == CMD_RECORD);
	assign hit = seen_c[MAX_ENTRIES];

	always_comb begin
		if (limit_q == '0) begin
			lim_eff = LIM_W'(1);
		end else if (LIM_W'(limit_q) > LIM_W'(MAX_ENTRIES)) begin
			lim_eff = LIM_W'(MAX_ENTRIES);
		end else begin
			lim_eff = LIM_W'(limit_q);
		end
	end

	assign room  = LIM_W'(occ_q) < lim_eff;
	// On a miss the row shifts through the last occupied rank, or one past it if there is room.
	assign bound = room ? (occ_q + OCC_W'(1)) : occ_q;

	always_comb begin
		if (hit) begin
			front       = acc_c[MAX_ENTRIES];
			front.count = (front.count == COUNT_MAX) ? front.count : (front.count + COUNT_W'(1));
		end else begin
			front.tag     = key_s1;
			front.count   = COUNT_W'(1);
			front.created = time_s1;
		end
	end

	assign acc_c[0]  = '0;
	assign seen_c[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic   in_range;
		logic   rank_hit;
		logic   shift_en;
		entry_t shift_data;

		assign in_range = OCC_W'(i) < occ_q;
		assign rank_hit = RK_W'(i) == RK_W'(read_rank);

		if (i == 0) begin : g_head
			assign shift_en   = upd;
			assign shift_data = front;
		end else begin : g_body
			// A hit at rank r pulls ranks below r down one place; cells past the hit hold.
			assign shift_en   = upd & (hit ? ~seen_c[i] : (OCC_W'(i) < bound));
			assign shift_data = held[i-1];
		end

		hklt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.in_range   (in_range),
			.rank_hit   (rank_hit),
			.shift_en   (shift_en),
			.seen_prev  (seen_c[i]),
			.shift_data (shift_data),
			.acc_prev   (acc_c[i]),
			.held       (held[i]),
			.seen       (seen_c[i+1]),
			.acc        (acc_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			occ_q    <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			valid_s1 <= accept;
			done_q   <= valid_s1;
			if (upd && !hit && room) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			key_s1  <= key_tag;
			time_s1 <= access_time;
		end
		if (valid_s1) begin
			if (cmd_s1 == CMD_RECORD) begin
				was_hit_q     <= hit;
				evicted_q     <= ~hit & ~room;
				entry_valid_q <= 1'b0;
				tag_q         <= front.tag;
				count_q       <= front.count;
				age_q         <= time_s1 - front.created;
			end else begin
				was_hit_q     <= 1'b0;
				evicted_q     <= 1'b0;
				entry_valid_q <= hit;
				tag_q         <= acc_c[MAX_ENTRIES].tag;
				count_q       <= acc_c[MAX_ENTRIES].count;
				age_q         <= hit ? (time_s1 - acc_c[MAX_ENTRIES].created) : '0;
			end
		end
	end

	assign done        = done_q;
	assign was_hit     = was_hit_q;
	assign evicted     = evicted_q;
	assign entry_valid = entry_valid_q;
	assign entry_tag   = tag_q;
	assign entry_count = count_q;
	assign entry_age   = age_q;

	`ASSERT_CLK(a_busy_after_accept, (start && !busy) |=> busy, "busy not raised after a transfer")
	`ASSERT_CLK(a_done_after_busy, busy |=> (done && !busy), "result not shown after the update cycle")
	`ASSERT_NEVER(a_occ_bound, occ_q > OCC_W'(MAX_ENTRIES), "occupancy above table size")
	`ASSERT_NEVER(a_hit_evict, done && ((was_hit && evicted) || (entry_valid && was_hit)),
		"conflicting result flags")

endmodule

>>> sv/hklt_cell.sv
`timescale 1ns / 1ps

module hklt_cell import hklt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       in_range,
	input  logic       rank_hit,
	input  logic       shift_en,
	input  logic       seen_prev,
	input  entry_t     shift_data,
	input  entry_t     acc_prev,
	output entry_t     held,
	output logic       seen,
	output entry_t     acc
);

	entry_t held_q;
	logic   sel_q;

	// A cell is selected by a tag match on record or by its rank on read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (ctrl.capture) begin
			sel_q <= in_range & (ctrl.is_read ? rank_hit : (held_q.tag == ctrl.key));
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			held_q <= shift_data;
		end
	end

	assign held = held_q;
	assign seen = seen_prev | sel_q;
	assign acc  = acc_prev | (sel_q ? held_q : entry_t'('0));

endmodule

>>> verif/hot_key_lru_tracker_unit_tb.sv
`timescale 1ns / 1ps

module hot_key_lru_tracker_unit_tb;
	import hklt_pkg::*;

	localparam int DEPTH          = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct packed {
		logic               hit;
		logic               evicted;
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  age;
	} lru_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               command = CMD_RECORD;
	logic [TAG_W-1:0]   key_tag = '0;
	logic [TIME_W-1:0]  access_time = '0;
	logic [RANK_W-1:0]  read_rank = '0;
	logic               done;
	logic               was_hit;
	logic               evicted;
	logic               entry_valid;
	logic [TAG_W-1:0]   entry_tag;
	logic [COUNT_W-1:0] entry_count;
	logic [TIME_W-1:0]  entry_age;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	// Local copy of the table that predicts every result.
	logic [TAG_W-1:0]   tag_mem [DEPTH];
	logic [COUNT_W-1:0] count_mem [DEPTH];
	logic [TIME_W-1:0]  born_mem [DEPTH];
	int                 rank_slot [DEPTH];
	int                 occupied_cnt = 0;
	logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

	lru_result_t        expected_results [$];
	int                 err_count = 0;
	int                 idle_pct = 0;
	int                 idle_cycles = 0;
	logic [TIME_W-1:0]  now_ts = '0;

	hot_key_lru_tracker_unit #(
		.MAX_ENTRIES(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.key_tag(key_tag),
		.access_time(access_time),
		.read_rank(read_rank),
		.done(done),
		.was_hit(was_hit),
		.evicted(evicted),
		.entry_valid(entry_valid),
		.entry_tag(entry_tag),
		.entry_count(entry_count),
		.entry_age(entry_age),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic void promote(int r);
		int s;
		s = rank_slot[r];
		for (int i = r; i > 0; i--)
			rank_slot[i] = rank_slot[i-1];
		rank_slot[0] = s;
	endfunction

	function automatic lru_result_t lru_predict(logic cmd, logic [TAG_W-1:0] tag,
			logic [TIME_W-1:0] tm, logic [RANK_W-1:0] rank);
		lru_result_t res;
		int lim;
		int r;
		int s;
		logic found;
		res = '0;
		found = 1'b0;
		r = 0;
		if (cmd == CMD_READ) begin
			if (int'(rank) < occupied_cnt) begin
				s = rank_slot[rank];
				res.valid = 1'b1;
				res.tag = tag_mem[s];
				res.count = count_mem[s];
				res.age = tm - born_mem[s];
			end
			return res;
		end
		while (!found && r < occupied_cnt) begin
			if (tag_mem[rank_slot[r]] == tag)
				found = 1'b1;
			else
				r++;
		end
		// A limit of zero behaves as one, anything past the table size as the table size.
		lim = (limit_reg == 0) ? 1 : ((int'(limit_reg) > DEPTH) ? DEPTH : int'(limit_reg));
		if (found) begin
			promote(r);
		end else begin
			if (occupied_cnt < lim) begin
				s = occupied_cnt;
				rank_slot[s] = s;
				r = s;
				occupied_cnt++;
			end else begin
				res.evicted = 1'b1;
				r = occupied_cnt - 1;
				s = rank_slot[r];
			end
			tag_mem[s] = tag;
			born_mem[s] = tm;
			count_mem[s] = '0;
			promote(r);
		end
		s = rank_slot[0];
		if (count_mem[s] != COUNT_MAX)
			count_mem[s] = count_mem[s] + 1'b1;
		res.hit = found;
		res.tag = tag_mem[s];
		res.count = count_mem[s];
		res.age = tm - born_mem[s];
		return res;
	endfunction

	task automatic send_cmd(logic cmd, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] tm,
			logic [RANK_W-1:0] rank);
		int gap;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		key_tag <= tag;
		access_time <= tm;
		read_rank <= rank;
		do @(posedge clk); while (busy);
		expected_results.insert(expected_results.size(), lru_predict(cmd, tag, tm, rank));
	endtask

	task automatic drain;
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_reg = value;
	endtask

	// Mostly records of tags already in the table or fresh ones, plus reads that
	// usually land on an occupied rank.
	task automatic random_cmd(int fresh_pct);
		logic [TAG_W-1:0] tag;
		logic [RANK_W-1:0] rank;
		logic cmd;
		now_ts = now_ts + $urandom_range(0, 2000);
		if ($urandom_range(19) == 0)
			now_ts = $urandom();
		tag = {$urandom(), $urandom()};
		rank = RANK_W'($urandom_range(63));
		cmd = ($urandom_range(99) < 30) ? CMD_READ : CMD_RECORD;
		if (cmd == CMD_READ && occupied_cnt > 0 && $urandom_range(99) < 70)
			rank = RANK_W'($urandom_range(occupied_cnt - 1));
		if (cmd == CMD_RECORD && occupied_cnt > 0 && $urandom_range(99) >= fresh_pct)
			tag = tag_mem[rank_slot[$urandom_range(occupied_cnt - 1)]];
		if ($urandom_range(199) == 0)
			drain();
		send_cmd(cmd, tag, now_ts, rank);
	endtask

	task automatic test_basic_sequence;
		send_cmd(CMD_READ, '1, 32'd5, 6'd0);
		send_cmd(CMD_RECORD, 64'h0, 32'h0, 6'd63);
		send_cmd(CMD_RECORD, '1, 32'hFFFF_FFFF, 6'd0);
		send_cmd(CMD_RECORD, 64'h0, 32'd100, 6'h2A);
		// The largest age, and an age that wraps past zero.
		send_cmd(CMD_READ, 64'h0, 32'hFFFF_FFFF, 6'd0);
		send_cmd(CMD_READ, '1, 32'h0, 6'd1);
		send_cmd(CMD_READ, 64'h0, 32'd7, 6'd2);
		send_cmd(CMD_READ, 64'h0, 32'd7, 6'd63);
		send_cmd(CMD_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 6'h15);
		send_cmd(CMD_RECORD, 64'h5555_5555_5555_5555, 32'h5555_5555, 6'h2A);
		for (int i = 0; i < 6; i++)
			send_cmd(CMD_RECORD, {$urandom(), $urandom()}, 32'd1000 + i, 6'd0);
		// The table now holds the reset limit of ten; the next miss replaces the least recently used entry.
		send_cmd(CMD_READ, 64'h0, 32'd2000, 6'd9);
		send_cmd(CMD_READ, 64'h0, 32'd2000, 6'd10);
		send_cmd(CMD_RECORD, 64'h8000_0000_0000_0001, 32'd2001, 6'd0);
		send_cmd(CMD_RECORD, tag_mem[rank_slot[9]], 32'd2002, 6'd0);
		send_cmd(CMD_READ, 64'h0, 32'd2003, 6'd0);
		now_ts = 32'd3000;
	endtask

	task automatic test_lowered_limit;
		write_limit(7'd1);
		repeat (150) random_cmd(30);
	endtask

	task automatic test_limit_zero;
		write_limit(7'd0);
		repeat (100) random_cmd(30);
	endtask

	task automatic test_limit_above_max;
		write_limit(7'd127);
		repeat (250) random_cmd(60);
		drain();
		now_ts = 32'hFFFF_F000;
		repeat (250) random_cmd(40);
	endtask

	task automatic test_full_table;
		write_limit(7'd64);
		repeat (400) random_cmd(35);
	endtask

	task automatic test_limit_sweep;
		logic [LIMIT_W-1:0] sweep [4];
		sweep[0] = 7'd2;
		sweep[1] = 7'd63;
		sweep[2] = LIMIT_W'($urandom_range(1, 64));
		sweep[3] = 7'd10;
		for (int i = 0; i < 4; i++) begin
			write_limit(sweep[i]);
			repeat (150) random_cmd(35);
		end
	endtask

	always @(posedge clk) begin : check_result
		lru_result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no command outstanding");
				err_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (was_hit !== exp_r.hit) begin
					$error("was_hit: expected %0h, got %0h", exp_r.hit, was_hit);
					err_count++;
				end
				if (evicted !== exp_r.evicted) begin
					$error("evicted: expected %0h, got %0h", exp_r.evicted, evicted);
					err_count++;
				end
				if (entry_valid !== exp_r.valid) begin
					$error("entry_valid: expected %0h, got %0h", exp_r.valid, entry_valid);
					err_count++;
				end
				if (entry_tag !== exp_r.tag) begin
					$error("entry_tag: expected %0h, got %0h", exp_r.tag, entry_tag);
					err_count++;
				end
				if (entry_count !== exp_r.count) begin
					$error("entry_count: expected %0h, got %0h", exp_r.count, entry_count);
					err_count++;
				end
				if (entry_age !== exp_r.age) begin
					$error("entry_age: expected %0h, got %0h", exp_r.age, entry_age);
					err_count++;
				end
			end
		end
	end

	// Any command, result or register transfer counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 18;
		test_basic_sequence();
		test_lowered_limit();
		test_limit_zero();
		idle_pct = 46;
		test_limit_above_max();
		test_full_table();
		idle_pct = 0;
		test_limit_sweep();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/hklt_pkg.sv
sv/hklt_cell.sv
sv/hot_key_lru_tracker_unit.sv
verif/hot_key_lru_tracker_unit_tb.sv
